// ----- src/prt_pkg.sv -----
`timescale 1ns / 1ps
package prt_pkg;
    localparam logic [2:0] ST_UPDATED  = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_EXACT    = 3'd3;
    localparam logic [2:0] ST_PREFIX   = 3'd4;
    localparam logic [2:0] ST_NOMATCH  = 3'd5;
    localparam logic ACT_UPDATE = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;
    localparam int POOL_BITS = 15;
endpackage

// ----- src/prefix_route_tree_engine.sv -----
`timescale 1ns / 1ps
// Routing table of prefix keys held as an unbalanced binary search tree in one
// node memory (key, value, left and right link per entry, synchronous read). One
// transaction is worked at a time and is accepted only while the walk is idle.
// Each tree node on the walk takes a read state (address) and then an evaluate
// state (registered read data). The walk ends when it runs off the tree (lookup
// without exact match, insert, pool full) or when it stops on an equal key; an
// insert below an existing node adds a state for the link write back. The result
// is loaded into an output register; while that register still holds an
// unaccepted result the finished walk waits in its last state.
// s_tdata: action[0], prefix_key[KEY_BITS:1], route_value[KEY_BITS+32:KEY_BITS+1].
// m_tdata: status[2:0], node_index, match_key, match_value, match_length, hop_count.
module prefix_route_tree_engine
    import prt_pkg::*;
#(
    parameter int NODE_COUNT = 16384,
    parameter int KEY_BITS   = 56
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // action, prefix_key, route_value from bit 0 up, zero padded to bytes
    input  logic [((KEY_BITS + 33 + 7) / 8) * 8 - 1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // status, node_index, match_key, match_value, match_length, hop_count
    output logic [((3 + ((NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1) + KEY_BITS + 32
                    + $clog2(KEY_BITS + 1) + $clog2(NODE_COUNT + 1) + 7) / 8) * 8 - 1:0]
                 m_tdata,
    input  logic cfg_wen,
    input  logic [POOL_BITS-1:0] cfg_wdata
);
    localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int CW = $clog2(NODE_COUNT + 1);       // link / count width
    localparam int IW = AW;
    localparam int LW = $clog2(KEY_BITS + 1);
    localparam int OW = 3 + IW + KEY_BITS + 32 + LW + CW;
    localparam int OB = ((OW + 7) / 8) * 8;
    localparam logic [CW-1:0] NIL = CW'(NODE_COUNT);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_LINK = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [31:0]         value;
        logic [CW-1:0]       left;
        logic [CW-1:0]       right;
    } node_t;

    node_t mem [NODE_COUNT];
    node_t rd_reg;
    logic  we;
    logic [AW-1:0] wa, ra;
    node_t wd;

    logic [2:0] state_reg, state_next;
    logic [POOL_BITS-1:0] limit_reg;
    logic [CW-1:0] root_reg, used_reg, cur_reg, cur_next, par_reg, par_next;
    logic par_right_reg, par_right_next;
    logic act_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [31:0] val_reg;
    logic [CW-1:0] hops_reg, hops_next, best_reg, best_next;
    logic [LW-1:0] blen_reg, blen_next;
    logic [KEY_BITS-1:0] bkey_reg, bkey_next;
    logic [31:0] bval_reg, bval_next;
    logic [2:0] st_reg, st_next;
    logic ov_reg;
    logic [OW-1:0] out_reg;
    logic done;

    // Node memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_reg <= mem[ra];
    end

    // Subnet length of node key against search key
    logic [LW-1:0] lead;
    logic [KEY_BITS-1:0] diff, low_bits;
    logic sub_ok;
    always_comb
    begin
        diff = rd_reg.key ^ key_reg;
        lead = '0;
        for (int b = 0; b < KEY_BITS; b++)
        begin
            if (diff[b])
            begin
                lead = LW'(KEY_BITS - 1 - b);
            end
        end
        low_bits = '0;
        for (int b = 0; b < KEY_BITS; b++)
        begin
            low_bits[b] = (b < KEY_BITS - int'(lead)) ? rd_reg.key[b] : 1'b0;
        end
        sub_ok = (lead != '0) && (low_bits == '0);
    end

    logic [CW-1:0] lim_eff;
    assign lim_eff = (CW'(limit_reg) < NIL && CW >= POOL_BITS) ? CW'(limit_reg) :
                     ((limit_reg < POOL_BITS'(NODE_COUNT)) ? CW'(limit_reg) : NIL);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata  = OB'(out_reg);

    // Walk control
    always_comb
    begin
        state_next = state_reg;
        cur_next = cur_reg; par_next = par_reg; par_right_next = par_right_reg;
        hops_next = hops_reg; best_next = best_reg; blen_next = blen_reg;
        bkey_next = bkey_reg; bval_next = bval_reg; st_next = st_reg;
        we = 1'b0; wa = cur_reg[AW-1:0]; wd = rd_reg; ra = cur_reg[AW-1:0];
        done = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    cur_next = root_reg; par_next = NIL; par_right_next = 1'b0;
                    hops_next = '0; best_next = '0; blen_next = '0;
                    bkey_next = '0; bval_next = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (cur_reg == NIL)
                begin
                    if (act_reg == ACT_LOOKUP)
                    begin
                        st_next = (blen_reg != '0) ? ST_PREFIX : ST_NOMATCH;
                        state_next = S_DONE;
                    end
                    else if (used_reg >= lim_eff)
                    begin
                        st_next = ST_FULL; best_next = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // write the new leaf
                        we = 1'b1; wa = used_reg[AW-1:0];
                        wd.key = key_reg; wd.value = val_reg;
                        wd.left = NIL; wd.right = NIL;
                        best_next = used_reg; st_next = ST_INSERTED;
                        ra = par_reg[AW-1:0];
                        state_next = (par_reg == NIL) ? S_DONE : S_LINK;
                    end
                end
                else
                begin
                    ra = cur_reg[AW-1:0];
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (rd_reg.key == key_reg)
                begin
                    best_next = cur_reg;
                    if (act_reg == ACT_LOOKUP)
                    begin
                        hops_next = hops_reg + 1'b1;
                        blen_next = LW'(KEY_BITS);
                        bkey_next = rd_reg.key; bval_next = rd_reg.value;
                        st_next = ST_EXACT;
                    end
                    else
                    begin
                        we = 1'b1; wd.value = val_reg; st_next = ST_UPDATED;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    if (act_reg == ACT_LOOKUP)
                    begin
                        hops_next = hops_reg + 1'b1;
                        if (sub_ok && lead > blen_reg)
                        begin
                            blen_next = lead; best_next = cur_reg;
                            bkey_next = rd_reg.key; bval_next = rd_reg.value;
                        end
                    end
                    par_next = cur_reg;
                    par_right_next = key_reg > rd_reg.key;
                    cur_next = (key_reg > rd_reg.key) ? rd_reg.right : rd_reg.left;
                    state_next = S_READ;
                end
            end
            S_LINK:
            begin
                // parent entry read back; patch its link to the new leaf
                we = 1'b1; wa = par_reg[AW-1:0];
                if (par_right_reg) wd.right = best_reg;
                else wd.left = best_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register can take the result
                if (!ov_reg || m_tready)
                begin
                    done = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; root_reg <= NIL; used_reg <= '0;
            limit_reg <= POOL_BITS'(16384); ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wen) limit_reg <= cfg_wdata;
            if (state_reg == S_READ && cur_reg == NIL && st_next == ST_INSERTED)
            begin
                used_reg <= used_reg + 1'b1;
                if (par_reg == NIL)
                    root_reg <= used_reg;
            end
            if (done) ov_reg <= 1'b1;
            else if (m_tready) ov_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            act_reg <= s_tdata[0];
            key_reg <= s_tdata[KEY_BITS:1];
            val_reg <= s_tdata[KEY_BITS+32:KEY_BITS+1];
        end
        cur_reg <= cur_next; par_reg <= par_next; par_right_reg <= par_right_next;
        hops_reg <= hops_next; best_reg <= best_next; blen_reg <= blen_next;
        bkey_reg <= bkey_next; bval_reg <= bval_next; st_reg <= st_next;
        if (done)
        begin
            if (st_reg == ST_NOMATCH)
                out_reg <= {hops_reg, LW'(0), 32'd0, KEY_BITS'(0), IW'(0), st_reg};
            else
                out_reg <= {hops_reg, blen_reg, bval_reg, bkey_reg,
                            best_reg[IW-1:0], st_reg};
        end
    end
endmodule

// ----- bench/route_checker.sv -----
`timescale 1ns / 1ps
module route_checker
    import prt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [95:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    input  logic         cfg_wen,
    input  logic [POOL_BITS-1:0] cfg_wdata,
    output int           errors,
    output int           pending
);
    localparam int NODES = 16384;
    localparam logic [14:0] NULL_LINK = 15'd16384;

    // Fields from the highest bit down; status sits in the lowest bits
    typedef struct packed {
        logic [14:0] hop_count;
        logic [5:0]  match_length;
        logic [31:0] match_value;
        logic [55:0] match_key;
        logic [13:0] node_index;
        logic [2:0]  status;
    } route_result_t;

    logic [55:0] tree_key   [NODES];
    logic [31:0] tree_value [NODES];
    logic [14:0] tree_left  [NODES];
    logic [14:0] tree_right [NODES];
    logic [14:0] root_index;
    logic [14:0] nodes_used;
    logic [14:0] node_limit;
    route_result_t expected_results [$];

    // Length by which node key a covers search key b, 0 when it does not
    function automatic int cover_length(logic [55:0] a, logic [55:0] b);
        logic [55:0] x;
        int len;
        x   = a ^ b;
        len = 0;
        for (int bit_pos = 55; bit_pos >= 0; bit_pos--)
        begin
            if (x[bit_pos])
                break;
            len++;
        end
        if (len < 56 && (a & ((56'd1 << (56 - len)) - 56'd1)) != 56'd0)
            return 0;
        return len;
    endfunction

    // Walk the tree for one transaction and update the table copy
    function automatic route_result_t route_predict(logic action, logic [55:0] key,
                                                    logic [31:0] value);
        route_result_t res;
        logic [14:0] cur;
        logic [14:0] parent;
        logic        go_right;
        logic [14:0] limit;
        logic [14:0] best;
        int          best_len;
        int          len;
        res      = '0;
        cur      = root_index;
        parent   = NULL_LINK;
        go_right = 1'b0;
        best     = '0;
        best_len = 0;
        if (action == ACT_UPDATE)
        begin
            limit = (node_limit < NULL_LINK) ? node_limit : NULL_LINK;
            while (cur != NULL_LINK && tree_key[cur] != key)
            begin
                parent   = cur;
                go_right = key > tree_key[cur];
                cur      = go_right ? tree_right[cur] : tree_left[cur];
            end
            if (cur != NULL_LINK)
            begin
                tree_value[cur] = value;
                res.status      = ST_UPDATED;
                res.node_index  = cur[13:0];
            end
            else if (nodes_used >= limit)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                tree_key[nodes_used]   = key;
                tree_value[nodes_used] = value;
                tree_left[nodes_used]  = NULL_LINK;
                tree_right[nodes_used] = NULL_LINK;
                if (parent == NULL_LINK)
                    root_index = nodes_used;
                else if (go_right)
                    tree_right[parent] = nodes_used;
                else
                    tree_left[parent] = nodes_used;
                res.status     = ST_INSERTED;
                res.node_index = nodes_used[13:0];
                nodes_used++;
            end
        end
        else
        begin
            while (cur != NULL_LINK)
            begin
                res.hop_count++;
                if (tree_key[cur] == key)
                begin
                    best     = cur;
                    best_len = 56;
                    break;
                end
                len = cover_length(tree_key[cur], key);
                if (len > best_len)
                begin
                    best_len = len;
                    best     = cur;
                end
                cur = (key > tree_key[cur]) ? tree_right[cur] : tree_left[cur];
            end
            if (best_len > 0)
            begin
                res.status       = (best_len == 56) ? ST_EXACT : ST_PREFIX;
                res.node_index   = best[13:0];
                res.match_key    = tree_key[best];
                res.match_value  = tree_value[best];
                res.match_length = best_len[5:0];
            end
            else
            begin
                res.status = ST_NOMATCH;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        route_result_t got;
        route_result_t want;
        if (!rst_n)
        begin
            root_index = NULL_LINK;
            nodes_used = '0;
            node_limit = 15'd16384;
            errors     = 0;
            expected_results.delete();
            pending    = 0;
        end
        else
        begin
            if (cfg_wen)
                node_limit = cfg_wdata;
            // Predict accepted input transactions
            if (s_tvalid && s_tready)
                expected_results.push_back(route_predict(s_tdata[0], s_tdata[56:1],
                                                         s_tdata[88:57]));
            // Compare accepted results with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                got = route_result_t'(m_tdata[125:0]);
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result", 64'(got.status), 64'd0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.node_index != want.node_index)
                        report_mismatch("node_index", 64'(got.node_index),
                                        64'(want.node_index));
                    if (got.match_key != want.match_key)
                        report_mismatch("match_key", 64'(got.match_key),
                                        64'(want.match_key));
                    if (got.match_value != want.match_value)
                        report_mismatch("match_value", 64'(got.match_value),
                                        64'(want.match_value));
                    if (got.match_length != want.match_length)
                        report_mismatch("match_length", 64'(got.match_length),
                                        64'(want.match_length));
                    if (got.hop_count != want.hop_count)
                        report_mismatch("hop_count", 64'(got.hop_count),
                                        64'(want.hop_count));
                end
            end
            pending = expected_results.size();
        end
    end
endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
    import prt_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic         cfg_wen;
    logic [POOL_BITS-1:0] cfg_wdata;
    int           errors;
    int           pending;
    int           cycles;
    int           hold_requests;
    int           holds_done;
    logic [55:0]  known_keys [$];

    prefix_route_tree_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    route_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 3000000)
            begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    // Receiver: stall pattern plus one long hold-off per request
    initial
    begin
        int mode;
        m_tready   = 1'b0;
        mode       = 0;
        holds_done = 0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_done)
            begin
                holds_done++;
                m_tready = 1'b0;
                repeat (600) @(negedge clk);
            end
            if ($urandom_range(0, 63) == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0: m_tready = 1'b1;
                1: m_tready = ($urandom_range(0, 3) != 0);
                2: m_tready = ($urandom_range(0, 3) == 0);
                default: m_tready = ~m_tready;
            endcase
        end
    end

    function automatic logic [55:0] random_key();
        return 56'({$urandom, $urandom} >> 8);
    endfunction

    // Clear the bits below the top len bits
    function automatic logic [55:0] keep_top(logic [55:0] key, int len);
        if (len >= 56)
            return key;
        return key & ~((56'd1 << (56 - len)) - 56'd1);
    endfunction

    function automatic logic [55:0] pick_known();
        if (known_keys.size() == 0)
            return random_key();
        return known_keys[$urandom_range(0, known_keys.size() - 1)];
    endfunction

    // Present one transaction and hold it until accepted
    task automatic send(logic action, logic [55:0] key, logic [31:0] value);
        s_tvalid = 1'b1;
        s_tdata  = {7'd0, value, key, action};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        if (action == ACT_UPDATE)
            known_keys.push_back(key);
    endtask

    task automatic idle(int n);
        s_tvalid = 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Wait for every result, then write the pool limit
    task automatic set_limit(logic [POOL_BITS-1:0] limit);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_wen   = 1'b1;
        cfg_wdata = limit;
        @(negedge clk);
        cfg_wen = 1'b0;
    endtask

    // Mostly structured keys so that prefixes and deep walks show up
    task automatic random_items(int count, bit hold_midway);
        logic        action;
        logic [55:0] key;
        int          burst;
        int          sent;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 24);
            repeat (burst)
            begin
                action = $urandom_range(0, 1);
                case ($urandom_range(0, 3))
                    0: key = random_key();
                    1: key = action ? pick_known()
                                    : keep_top(random_key(), $urandom_range(1, 55));
                    2: key = keep_top(pick_known(), $urandom_range(1, 55));
                    default: key = action
                        ? keep_top(pick_known(), $urandom_range(1, 55))
                          | (random_key() >> $urandom_range(1, 56))
                        : pick_known();
                endcase
                send(action, key, $urandom);
                sent++;
                if (hold_midway && sent == count / 2)
                    hold_requests++;
            end
            if ($urandom_range(0, 2) != 0)
                idle($urandom_range(1, 12));
        end
        s_tvalid = 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_wen       = 1'b0;
        cfg_wdata     = '0;
        hold_requests = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty tree, extremes, update, exact and prefix matches
        send(ACT_LOOKUP, 56'h12_3456_789A_BCDE, 32'hFFFF_FFFF);
        send(ACT_UPDATE, 56'h80_0000_0000_0000, 32'h0000_0000);
        send(ACT_UPDATE, 56'h00_0000_0000_0000, 32'hFFFF_FFFF);
        send(ACT_UPDATE, 56'hFF_FFFF_FFFF_FFFF, 32'h1234_5678);
        send(ACT_UPDATE, 56'h80_0000_0000_0000, 32'hFFFF_FFFF);
        send(ACT_UPDATE, 56'hC0_FF00_0000_0000, 32'hA5A5_A5A5);
        send(ACT_LOOKUP, 56'h80_0000_0000_0000, 32'h0);
        send(ACT_LOOKUP, 56'hFF_FFFF_FFFF_FFFF, 32'h0);
        send(ACT_LOOKUP, 56'h00_0000_0000_0000, 32'h0);
        send(ACT_LOOKUP, 56'hC0_FF12_3456_789A, 32'h0);
        send(ACT_LOOKUP, 56'h80_0000_0000_0001, 32'h0);
        send(ACT_LOOKUP, 56'h7F_FFFF_FFFF_FFFF, 32'h0);
        send(ACT_LOOKUP, 56'hFF_FFFF_FFFF_FFFE, 32'h0);
        // Ascending keys build a long chain
        for (int k = 1; k <= 12; k++)
            send(ACT_UPDATE, 56'h40_0000_0000_0000 + 56'(k), 32'(k));
        send(ACT_LOOKUP, 56'h40_0000_0000_000C, 32'h0);

        // Pool full at a zero limit and at a limit of one
        set_limit(15'd0);
        send(ACT_UPDATE, 56'h11_2233_4455_6677, 32'h1);
        send(ACT_UPDATE, 56'h80_0000_0000_0000, 32'h2);
        set_limit(15'd1);
        send(ACT_UPDATE, 56'h11_2233_4455_6677, 32'h3);

        set_limit(15'h7FFF);
        random_items(300, 1'b1);
        set_limit(15'd250);
        random_items(300, 1'b0);
        set_limit(15'd16384);
        random_items(300, 1'b0);
        set_limit(15'd1);
        random_items(230, 1'b0);

        while (pending != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
